// ----- hw/rtl/dtcc_pkg.sv -----
// Shared constants, pipeline transfer types and calendar tables for the
// date to chart cycle unit. No dependencies.
`default_nettype none

package dtcc_pkg;

	localparam int unsigned CYCLE_DAYS       = 28;
	localparam int unsigned CYCLES_PER_GROUP = 13;
	localparam int unsigned BASE_YEAR        = 26;
	localparam int unsigned YEAR_MOD         = 100;

	// March-based year shifted by 400 keeps every day number positive
	localparam int unsigned YEAR_SHIFT  = 400;
	localparam int unsigned ANCHOR_YEAR = 2026;
	localparam int unsigned ANCHOR_DAY  = 22;
	// Anchor falls in January, so it belongs to the previous March-based year
	localparam int unsigned ANCHOR_ADJ  = ANCHOR_YEAR + YEAR_SHIFT - 1;
	localparam int unsigned JAN_BASE    = 306;
	localparam int unsigned ANCHOR_DAYNUM = 365 * ANCHOR_ADJ + ANCHOR_ADJ / 4
		- ANCHOR_ADJ / 100 + ANCHOR_ADJ / 400 + JAN_BASE + ANCHOR_DAY - 1;

	// Bias the count by a whole number of groups so it never goes negative
	// and so the group count lands directly on the cycle year modulo 100.
	localparam int unsigned GROUP_SHIFT = YEAR_MOD * 21 + BASE_YEAR;
	localparam int unsigned DAY_BIAS    = ANCHOR_DAYNUM
		- GROUP_SHIFT * CYCLE_DAYS * CYCLES_PER_GROUP;

	// Reciprocals for constant division: floor(x * R >> S)
	localparam int unsigned RECIP25 = 5243;     // shift 17, exact for x < 43690
	localparam int unsigned RECIP7  = 2396746;  // shift 24, exact for x < 2796202
	localparam int unsigned RECIP13 = 322639;   // shift 22, exact for x < 1398101

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;

	typedef struct packed {
		logic        vld;
		logic        ok;
		logic [22:0] ofs;   // biased day count
	} day_count_t;

	typedef struct packed {
		logic        vld;
		logic        ok;
		logic [3:0]  rem;   // cycle within the group, 0 to 12
		logic [14:0] grp;   // biased group count
		logic [7:0]  hund;  // group count divided by 100
	} cycle_pipe_t;

	function automatic logic [4:0] month_len(input logic [3:0] month);
		logic [4:0] len;
		unique case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	// Days before the first of the month in a year that starts in March
	function automatic logic [8:0] march_base(input logic [3:0] month);
		logic [8:0] base;
		unique case (month)
			4'd3:    base = 9'd0;
			4'd4:    base = 9'd31;
			4'd5:    base = 9'd61;
			4'd6:    base = 9'd92;
			4'd7:    base = 9'd122;
			4'd8:    base = 9'd153;
			4'd9:    base = 9'd184;
			4'd10:   base = 9'd214;
			4'd11:   base = 9'd245;
			4'd12:   base = 9'd275;
			4'd1:    base = 9'd306;
			4'd2:    base = 9'd337;
			default: base = 9'd0;
		endcase
		return base;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dtcc_date_stage.sv -----
// Stages 1 and 2: date check, leap year test and biased day count.
// Depends on dtcc_pkg.
`default_nettype none

module dtcc_date_stage (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_vld,
	input  wire  [13:0]              cal_year,
	input  wire  [3:0]               cal_month,
	input  wire  [4:0]               cal_day,
	output dtcc_pkg::day_count_t     cnt_s2
);
	import dtcc_pkg::*;

	logic        early;
	logic [14:0] adj_year;
	logic [25:0] prod100;
	logic [23:0] prod400;
	logic [26:0] prod25;

	logic        vld_s1;
	logic [13:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [14:0] adj_s1;
	logic [7:0]  q100_s1;
	logic [5:0]  q400_s1;
	logic [9:0]  q25_s1;

	logic        leap;
	logic        cent;
	logic [4:0]  mlen;
	logic        ok;
	logic [23:0] daynum;

	logic        vld_s2;
	logic        ok_s2;
	logic [22:0] ofs_s2;

	// Stage 1: shift the year to start in March, divide by 100, 400 and 25
	always_comb begin
		early    = (cal_month <= MONTH_FEB);
		adj_year = 15'(cal_year) + 15'(YEAR_SHIFT) - {14'd0, early};
		prod100  = 26'(adj_year[14:2]) * 26'(RECIP25);
		prod400  = 24'(adj_year[14:4]) * 24'(RECIP25);
		prod25   = 27'(cal_year) * 27'(RECIP25);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		year_s1  <= cal_year;
		month_s1 <= cal_month;
		day_s1   <= cal_day;
		adj_s1   <= adj_year;
		q100_s1  <= prod100[24:17];
		q400_s1  <= prod400[22:17];
		q25_s1   <= prod25[26:17];
	end

	// Stage 2: month length check and day number
	always_comb begin
		cent   = (year_s1 == 14'(q25_s1) * 14'd25);
		leap   = (year_s1[1:0] == 2'd0) && (!cent || (year_s1[3:0] == 4'd0));
		mlen   = month_len(month_s1) + {4'd0, leap && (month_s1 == MONTH_FEB)};
		ok     = (day_s1 != 5'd0) && (day_s1 <= mlen);
		daynum = 24'(adj_s1) * 24'd365 + 24'(adj_s1[14:2]) - 24'(q100_s1)
			+ 24'(q400_s1) + 24'(march_base(month_s1)) + 24'(day_s1)
			- 24'd1 - 24'(DAY_BIAS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s2  <= ok;
		ofs_s2 <= daynum[22:0];
	end

	assign cnt_s2.vld = vld_s2;
	assign cnt_s2.ok  = ok_s2;
	assign cnt_s2.ofs = ofs_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/dtcc_div_stage.sv -----
// Stages 3 to 5: divide the day count by 28, then by 13 and by 100.
// Depends on dtcc_pkg.
`default_nettype none

module dtcc_div_stage (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire dtcc_pkg::day_count_t cnt_s2,
	output dtcc_pkg::cycle_pipe_t    cyc_s5
);
	import dtcc_pkg::*;

	logic [42:0] prod7;
	logic [36:0] prod13;
	logic [17:0] rem_full;
	logic [25:0] prod100;

	logic        vld_s3;
	logic        ok_s3;
	logic [17:0] g_s3;

	logic        vld_s4;
	logic        ok_s4;
	logic [17:0] g_s4;
	logic [14:0] q_s4;

	logic        vld_s5;
	logic        ok_s5;
	logic [3:0]  rem_s5;
	logic [14:0] q_s5;
	logic [7:0]  t_s5;

	// Divide by 4 is a shift, the remaining 7 a reciprocal multiply
	assign prod7    = 43'(cnt_s2.ofs[22:2]) * 43'(RECIP7);
	assign prod13   = 37'(g_s3) * 37'(RECIP13);
	assign rem_full = g_s4 - 18'(q_s4) * 18'd13;
	assign prod100  = 26'(q_s4[14:2]) * 26'(RECIP25);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s3 <= cnt_s2.vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		ok_s3  <= cnt_s2.ok;
		g_s3   <= prod7[41:24];
		ok_s4  <= ok_s3;
		g_s4   <= g_s3;
		q_s4   <= prod13[36:22];
		ok_s5  <= ok_s4;
		rem_s5 <= rem_full[3:0];
		q_s5   <= q_s4;
		t_s5   <= prod100[24:17];
	end

	assign cyc_s5.vld  = vld_s5;
	assign cyc_s5.ok   = ok_s5;
	assign cyc_s5.rem  = rem_s5;
	assign cyc_s5.grp  = q_s5;
	assign cyc_s5.hund = t_s5;

endmodule

`default_nettype wire

// ----- hw/rtl/date_to_chart_cycle_unit.sv -----
// Date to 28-day chart cycle: every start transfer gives one done strobe;
// throughput one date per cycle, busy never rises.
// Six register stages: year shift and divide, date check and day count,
// divide by 28, divide by 13, divide by 100, output register. The receiver
// cannot stall the pipe. Asynchronous active-low reset clears all valid bits
// and done. Depends on dtcc_pkg, dtcc_date_stage and dtcc_div_stage.
`default_nettype none

module date_to_chart_cycle_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [13:0] cal_year,
	input  wire  [3:0]  cal_month,
	input  wire  [4:0]  cal_day,
	output logic        done,
	output logic        date_valid,
	output logic [6:0]  chart_year,
	output logic [3:0]  cycle_index
);
	import dtcc_pkg::*;

	day_count_t  cnt_s2;
	cycle_pipe_t cyc_s5;
	logic        accept;
	logic [14:0] year_full;

	logic        done_q;
	logic        date_valid_q;
	logic [6:0]  chart_year_q;
	logic [3:0]  cycle_index_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	dtcc_date_stage u_date (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (accept),
		.cal_year  (cal_year),
		.cal_month (cal_month),
		.cal_day   (cal_day),
		.cnt_s2    (cnt_s2)
	);

	dtcc_div_stage u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cnt_s2 (cnt_s2),
		.cyc_s5 (cyc_s5)
	);

	// Group count is biased to a multiple of 100 past the base year
	assign year_full = cyc_s5.grp - 15'(cyc_s5.hund) * 15'd100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cyc_s5.vld;
		end
	end

	// Drop the fields to zero for a date that does not exist
	always_ff @(posedge clk) begin
		date_valid_q  <= cyc_s5.ok;
		chart_year_q  <= cyc_s5.ok ? year_full[6:0] : 7'd0;
		cycle_index_q <= cyc_s5.ok ? cyc_s5.rem + 4'd1 : 4'd0;
	end

	assign done        = done_q;
	assign date_valid  = date_valid_q;
	assign chart_year  = chart_year_q;
	assign cycle_index = cycle_index_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dtcc_checker.sv -----
// Port-level checks for date_to_chart_cycle_unit, with the bind that
// attaches them. No package dependency.
`default_nettype none

module dtcc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire [3:0]  cal_month,
	input wire [4:0]  cal_day,
	input wire        done,
	input wire        date_valid,
	input wire [6:0]  chart_year,
	input wire [3:0]  cycle_index
);

	// Every result follows an earlier start transfer
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("done without a matching start transfer");

	// Every start transfer yields a result
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("start transfer produced no result");

	// A valid result never comes from a nonexistent month or day zero
	a_valid_date_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && date_valid) |-> ($past(cal_month, 6) >= 4'd1
			&& $past(cal_month, 6) <= 4'd12 && $past(cal_day, 6) != 5'd0))
		else $error("valid result for an impossible date");

	// Valid results stay in range, invalid ones carry zeros
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (date_valid ? (cycle_index >= 4'd1 && cycle_index <= 4'd13
			&& chart_year <= 7'd99) : (cycle_index == 4'd0 && chart_year == 7'd0)))
		else $error("result fields out of range");

endmodule

bind date_to_chart_cycle_unit dtcc_checker u_dtcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.cal_month   (cal_month),
	.cal_day     (cal_day),
	.done        (done),
	.date_valid  (date_valid),
	.chart_year  (chart_year),
	.cycle_index (cycle_index)
);

`default_nettype wire

// ----- sim/tb_date_to_chart_cycle_unit.sv -----
// Testbench for date_to_chart_cycle_unit: drives dates in bursts, predicts each
// chart cycle in a small scoreboard class and checks every done strobe.
// Depends on dtcc_pkg and the date_to_chart_cycle_unit RTL.

module tb_date_to_chart_cycle_unit;

	import dtcc_pkg::*;

	typedef struct packed {
		logic       date_valid;
		logic [6:0] chart_year;
		logic [3:0] cycle_index;
	} chart_cycle_t;

	class chart_cycle_board;
		chart_cycle_t cycles_due[$];
		int unsigned  mismatches;
		int unsigned  results_seen;
		int unsigned  dates_noted;
		int unsigned  dates_real;

		function bit leap_year(int unsigned y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		function int unsigned month_days(int unsigned y, int unsigned m);
			int unsigned len;
			case (m)
				1, 3, 5, 7, 8, 10, 12: len = 31;
				4, 6, 9, 11:           len = 30;
				MONTH_FEB:             len = leap_year(y) ? 29 : 28;
				default:               len = 0;
			endcase
			return len;
		endfunction

		// Serial day number on a March-based calendar, year moved up by 400
		function longint day_serial(int unsigned y, int unsigned m, int unsigned d);
			int unsigned march_offs[12] = '{0, 31, 61, 92, 122, 153, 184, 214, 245,
				275, 306, 337};
			longint      ys;
			int unsigned mi;
			ys = longint'(y) + 400;
			if (m <= MONTH_FEB) begin
				ys = ys - 1;
				mi = m + 9;
			end else begin
				mi = m - 3;
			end
			return 365 * ys + ys / 4 - ys / 100 + ys / 400 + march_offs[mi] + d - 1;
		endfunction

		function longint floor_quot(longint v, longint d);
			if (v >= 0)
				return v / d;
			return -((-v + d - 1) / d);
		endfunction

		function chart_cycle_t predict_cycle(logic [13:0] y, logic [3:0] m, logic [4:0] d);
			chart_cycle_t res;
			longint       span;
			longint       cyc_all;
			longint       grp;
			res = '0;
			if (d == 0 || d > month_days(y, m))
				return res;
			span    = day_serial(y, m, d) - day_serial(ANCHOR_YEAR, MONTH_JAN, ANCHOR_DAY);
			cyc_all = floor_quot(span, CYCLE_DAYS);
			grp     = floor_quot(cyc_all, CYCLES_PER_GROUP);
			res.date_valid  = 1'b1;
			res.cycle_index = 4'(cyc_all - grp * CYCLES_PER_GROUP + 1);
			// Keep the modulo signed so years before the anchor wrap correctly
			res.chart_year  = 7'(((longint'(BASE_YEAR) + grp) % longint'(YEAR_MOD)
				+ longint'(YEAR_MOD)) % longint'(YEAR_MOD));
			return res;
		endfunction

		function void note_date(logic [13:0] y, logic [3:0] m, logic [4:0] d);
			chart_cycle_t res;
			res = predict_cycle(y, m, d);
			cycles_due.insert(cycles_due.size(), res);
			dates_noted++;
			if (res.date_valid)
				dates_real++;
		endfunction

		function void check_result(chart_cycle_t got);
			chart_cycle_t want;
			results_seen++;
			if (cycles_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: valid=%b year=%0d index=%0d",
						got.date_valid, got.chart_year, got.cycle_index);
				return;
			end
			want = cycles_due.pop_front();
			if (got.date_valid !== want.date_valid || got.chart_year !== want.chart_year
					|| got.cycle_index !== want.cycle_index) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on result %0d: valid %b/%b year %0d/%0d index %0d/%0d",
						results_seen, want.date_valid, got.date_valid, want.chart_year,
						got.chart_year, want.cycle_index, got.cycle_index);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [13:0] cal_year;
	logic [3:0]  cal_month;
	logic [4:0]  cal_day;
	logic        done;
	logic        date_valid;
	logic [6:0]  chart_year;
	logic [3:0]  cycle_index;

	chart_cycle_board board = new();
	int unsigned      dates_sent;

	date_to_chart_cycle_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cal_year    (cal_year),
		.cal_month   (cal_month),
		.cal_day     (cal_day),
		.done        (done),
		.date_valid  (date_valid),
		.chart_year  (chart_year),
		.cycle_index (cycle_index)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Note each transfer and check each strobe with pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_date(cal_year, cal_month, cal_day);
			if (done)
				board.check_result('{date_valid, chart_year, cycle_index});
		end
	end

	task automatic send_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d);
		start     <= 1'b1;
		cal_year  <= y;
		cal_month <= m;
		cal_day   <= d;
		do @(posedge clk); while (busy);
		dates_sent++;
	endtask

	// Drop start and scramble the fields while idle
	task automatic idle_gap(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) begin
			cal_year  <= 14'($urandom);
			cal_month <= 4'($urandom);
			cal_day   <= 5'($urandom);
			@(posedge clk);
		end
	endtask

	task automatic send_random_date();
		int unsigned pick;
		int unsigned y;
		int unsigned m;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			send_date(14'($urandom_range(0, 16383)), 4'($urandom_range(0, 15)),
				5'($urandom_range(0, 31)));
		end else begin
			y = (pick < 50) ? $urandom_range(0, 16383) : $urandom_range(1900, 2200);
			m = $urandom_range(1, 12);
			send_date(14'(y), 4'(m), 5'($urandom_range(1, board.month_days(y, m))));
		end
	endtask

	initial begin
		int unsigned burst;
		int unsigned gap;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cal_year  <= '0;
		cal_month <= '0;
		cal_day   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Anchor and its neighbors, leap rules, bad dates and field extremes
		send_date(14'd2026, 4'd1, 5'd22);
		send_date(14'd2026, 4'd1, 5'd21);
		send_date(14'd2026, 4'd2, 5'd19);
		send_date(14'd2026, 4'd2, 5'd18);
		send_date(14'd2026, 4'd12, 5'd31);
		send_date(14'd0, 4'd1, 5'd1);
		send_date(14'd0, 4'd2, 5'd29);
		send_date(14'd2000, 4'd2, 5'd29);
		send_date(14'd2024, 4'd2, 5'd29);
		send_date(14'd1900, 4'd2, 5'd29);
		send_date(14'd2023, 4'd2, 5'd29);
		send_date(14'd2023, 4'd2, 5'd28);
		send_date(14'd2026, 4'd4, 5'd31);
		send_date(14'd2026, 4'd0, 5'd10);
		send_date(14'd2026, 4'd13, 5'd10);
		send_date(14'd16383, 4'd15, 5'd31);
		send_date(14'd2026, 4'd6, 5'd0);
		send_date(14'd9999, 4'd12, 5'd31);
		send_date(14'd16383, 4'd12, 5'd31);
		send_date(14'd16000, 4'd2, 5'd29);
		send_date(14'd16100, 4'd2, 5'd29);
		send_date(14'd1, 4'd3, 5'd1);
		send_date(14'd2525, 4'd7, 5'd15);

		while (dates_sent < 1850) begin
			burst = $urandom_range(1, 48);
			repeat (burst)
				send_random_date();
			case ($urandom_range(0, 3))
				0:       gap = 0;
				1:       gap = 1;
				2:       gap = $urandom_range(2, 5);
				default: gap = $urandom_range(6, 15);
			endcase
			if (gap != 0)
				idle_gap(gap);
		end
		start <= 1'b0;

		while (board.cycles_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("sent %0d dates (%0d real, %0d rejected), checked %0d results",
			board.dates_noted, board.dates_real, board.dates_noted - board.dates_real,
			board.results_seen);
		$display("%0d mismatches", board.mismatches);
		if (board.mismatches == 0 && board.cycles_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", board.cycles_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
